// ----- src/rau_pkg.sv -----
// shared constants for the rational arithmetic unit
package rau_pkg;

  localparam logic [1:0] KIND_ADD = 2'd0;
  localparam logic [1:0] KIND_SUB = 2'd1;
  localparam logic [1:0] KIND_MUL = 2'd2;
  localparam logic [1:0] KIND_DIV = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_ZDEN = 2'd1;
  localparam logic [1:0] ST_DIV0 = 2'd2;
  localparam logic [1:0] ST_OVF  = 2'd3;

  localparam logic [1:0] PH_A = 2'd0;
  localparam logic [1:0] PH_B = 2'd1;
  localparam logic [1:0] PH_R = 2'd2;

endpackage

// ----- src/rau_div.sv -----
// iterative restoring divider, one quotient bit per cycle
module rau_div #(
  parameter int DW = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [DW-1:0] divisor,
  output logic          busy,
  output logic          done,
  output logic [DW-1:0] quot,
  output logic [DW-1:0] rem
);

  localparam int CW = $clog2(DW + 1);

  logic [DW-1:0] q;
  logic [DW-1:0] r;
  logic [DW-1:0] dvs;
  logic [CW-1:0] cnt;
  logic [DW:0]   trial;

  assign trial = {r, q[DW-1]} - {1'b0, dvs};
  assign busy  = (cnt != '0);
  assign quot  = q;
  assign rem   = r;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        q   <= dividend;
        r   <= '0;
        dvs <= divisor;
        cnt <= CW'(DW);
      end else if (cnt != '0) begin
        if (!trial[DW]) begin
          r <= trial[DW-1:0];
          q <= {q[DW-2:0], 1'b1};
        end else begin
          r <= {r[DW-2:0], q[DW-1]};
          q <= {q[DW-2:0], 1'b0};
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- src/rational_arithmetic_unit.sv -----
// top level: sequencer, shared multiplier and gcd reduction around one divider
//
//  channel | signals                               | transaction
//  in      | in_valid in_ready kind a_* b_*        | two fractions and an operation
//  out     | out_valid out_ready res_num res_den   | reduced fraction and status
//           status
//
// three gcd reductions, each a series of remainder steps plus two quotients
// on the shared divider, plus three multiplies and the control states per
// transaction
// in_ready only in idle; a finished result waits in the output register
// synchronous reset clears the sequencer and the output valid
module rational_arithmetic_unit #(
  parameter int OPERAND_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [31:0] a_num,
  input  logic [31:0] a_den,
  input  logic [31:0] b_num,
  input  logic [31:0] b_den,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] res_num,
  output logic [30:0] res_den,
  output logic [1:0]  status
);

  localparam int W  = OPERAND_WIDTH;
  localparam int DW = 2 * OPERAND_WIDTH;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RED   = 4'd1;
  localparam logic [3:0] S_GCD   = 4'd2;
  localparam logic [3:0] S_NUM   = 4'd3;
  localparam logic [3:0] S_DEN   = 4'd4;
  localparam logic [3:0] S_STORE = 4'd5;
  localparam logic [3:0] S_MUL1  = 4'd6;
  localparam logic [3:0] S_MUL2  = 4'd7;
  localparam logic [3:0] S_MUL3  = 4'd8;
  localparam logic [3:0] S_COMB  = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  function automatic logic [W-1:0] mag(input logic [W-1:0] v);
    mag = v[W-1] ? (~v + 1'b1) : v;
  endfunction

  logic [3:0]    state;
  logic [1:0]    phase;
  logic [1:0]    kind_q;
  logic [1:0]    st_q;
  logic [W-1:0]  an, ad, bn, bd;
  logic          aneg, bneg, rneg;
  logic [DW-1:0] rn, rd, x;
  logic [DW-1:0] m1, m2, m3;

  logic          div_start, div_busy, div_done;
  logic [DW-1:0] div_dividend, div_divisor, div_quot, div_rem;

  logic [W-1:0]  mul_a, mul_b;
  logic [DW-1:0] prod;

  logic          s1, s2, ovf;
  logic [DW-1:0] sum_nm;
  logic          sum_neg;
  logic          in_zden;

  rau_div #(.DW(DW)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .busy     (div_busy),
    .done     (div_done),
    .quot     (div_quot),
    .rem      (div_rem)
  );

  assign in_ready = (state == S_IDLE);
  assign in_zden  = (a_den[W-1:0] == '0) || (b_den[W-1:0] == '0);
  assign prod     = mul_a * mul_b;
  assign ovf      = (rn[DW-1:W-1] != '0) || (rd[DW-1:W-1] != '0);

  // divider drive per sequencer step
  always_comb begin
    div_start    = 1'b0;
    div_dividend = rd;
    div_divisor  = rn;
    unique case (state)
      S_RED: begin
        div_start = (rn != '0) && (rd != '0);
      end
      S_GCD: begin
        if (div_done) begin
          div_start = 1'b1;
          if (div_rem == '0) begin
            div_dividend = rn;
            div_divisor  = x;
          end else begin
            div_dividend = x;
            div_divisor  = div_rem;
          end
        end
      end
      S_NUM: begin
        div_start    = div_done;
        div_dividend = rd;
        div_divisor  = x;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  // shared multiplier operand select
  always_comb begin
    mul_a = an;
    mul_b = bd;
    unique case (state)
      S_MUL1: begin
        mul_a = an;
        mul_b = (kind_q == rau_pkg::KIND_MUL) ? bn : bd;
      end
      S_MUL2: begin
        mul_a = bn;
        mul_b = ad;
      end
      S_MUL3: begin
        mul_a = ad;
        mul_b = (kind_q == rau_pkg::KIND_DIV) ? bn : bd;
      end
      default: begin
        mul_a = an;
        mul_b = bd;
      end
    endcase
  end

  // signed add or subtract of the cross products
  always_comb begin
    s1 = aneg;
    s2 = (kind_q == rau_pkg::KIND_SUB) ? !bneg : bneg;
    if (m2 == '0) begin
      s2 = s1;
    end
    if (m1 == '0) begin
      s1 = s2;
    end
    if (s1 == s2) begin
      sum_nm  = m1 + m2;
      sum_neg = s1;
    end else if (m1 >= m2) begin
      sum_nm  = m1 - m2;
      sum_neg = s1;
    end else begin
      sum_nm  = m2 - m1;
      sum_neg = s2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
      phase     <= rau_pkg::PH_A;
    end else begin
      if (out_valid && out_ready && (state != S_OUT)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            kind_q <= kind;
            if (in_zden) begin
              st_q  <= rau_pkg::ST_ZDEN;
              rn    <= '0;
              rd    <= '0;
              rneg  <= 1'b0;
              state <= S_OUT;
            end else begin
              rn    <= DW'(mag(a_num[W-1:0]));
              rd    <= DW'(mag(a_den[W-1:0]));
              rneg  <= a_num[W-1] ^ a_den[W-1];
              bn    <= mag(b_num[W-1:0]);
              bd    <= mag(b_den[W-1:0]);
              bneg  <= b_num[W-1] ^ b_den[W-1];
              phase <= rau_pkg::PH_A;
              state <= S_RED;
            end
          end
        end
        S_RED: begin
          if ((rn == '0) || (rd == '0)) begin
            rn    <= '0;
            rd    <= DW'(1);
            rneg  <= 1'b0;
            state <= S_STORE;
          end else begin
            x     <= rn;
            state <= S_GCD;
          end
        end
        S_GCD: begin
          if (div_done) begin
            if (div_rem == '0) begin
              state <= S_NUM;
            end else begin
              x <= div_rem;
            end
          end
        end
        S_NUM: begin
          if (div_done) begin
            rn    <= div_quot;
            state <= S_DEN;
          end
        end
        S_DEN: begin
          if (div_done) begin
            rd    <= div_quot;
            state <= S_STORE;
          end
        end
        S_STORE: begin
          priority case (phase)
            rau_pkg::PH_A: begin
              an    <= rn[W-1:0];
              ad    <= rd[W-1:0];
              aneg  <= rneg;
              rn    <= DW'(bn);
              rd    <= DW'(bd);
              rneg  <= bneg;
              phase <= rau_pkg::PH_B;
              state <= S_RED;
            end
            rau_pkg::PH_B: begin
              bn   <= rn[W-1:0];
              bd   <= rd[W-1:0];
              bneg <= rneg;
              if ((kind_q == rau_pkg::KIND_DIV) && (rn == '0)) begin
                st_q  <= rau_pkg::ST_DIV0;
                rn    <= '0;
                rd    <= '0;
                rneg  <= 1'b0;
                state <= S_OUT;
              end else begin
                state <= S_MUL1;
              end
            end
            default: begin
              if (ovf) begin
                st_q <= rau_pkg::ST_OVF;
                rn   <= '0;
                rd   <= '0;
                rneg <= 1'b0;
              end else begin
                st_q <= rau_pkg::ST_OK;
              end
              state <= S_OUT;
            end
          endcase
        end
        S_MUL1: begin
          m1    <= prod;
          state <= S_MUL2;
        end
        S_MUL2: begin
          m2    <= prod;
          state <= S_MUL3;
        end
        S_MUL3: begin
          m3    <= prod;
          state <= S_COMB;
        end
        S_COMB: begin
          if ((kind_q == rau_pkg::KIND_ADD) || (kind_q == rau_pkg::KIND_SUB)) begin
            rn   <= sum_nm;
            rneg <= sum_neg;
          end else begin
            rn   <= m1;
            rneg <= aneg ^ bneg;
          end
          rd    <= m3;
          phase <= rau_pkg::PH_R;
          state <= S_RED;
        end
        S_OUT: begin
          if (!out_valid || out_ready) begin
            res_num   <= rneg ? (32'd0 - 32'(rn[W-2:0])) : 32'(rn[W-2:0]);
            res_den   <= 31'(rd[W-2:0]);
            status    <= st_q;
            out_valid <= 1'b1;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_div_start_idle: assert property (@(posedge clk) disable iff (rst)
    div_start |-> !div_busy)
    else $error("divider restarted while busy");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != rau_pkg::ST_OK)) |-> ((res_num == 32'd0) && (res_den == 31'd0)))
    else $error("error result carries a value");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second transaction taken while busy");

endmodule

// ----- verif/rational_arithmetic_unit_checker.sv -----
// checker for the rational arithmetic unit: predicts and compares each result
module rational_arithmetic_unit_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [1:0]  kind,
  input  logic [31:0] a_num,
  input  logic [31:0] a_den,
  input  logic [31:0] b_num,
  input  logic [31:0] b_den,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [31:0] res_num,
  input  logic [30:0] res_den,
  input  logic [1:0]  status,
  output int          errors,
  output int          pending,
  output int          results_seen
);

  typedef struct packed {
    logic [31:0] num;
    logic [30:0] den;
    logic [1:0]  st;
  } fraction_t;

  fraction_t expected_fractions[$];

  function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
    logic [63:0] t;
    while (x != 0) begin
      t = y % x;
      y = x;
      x = t;
    end
    return (y == 0) ? 64'd1 : y;
  endfunction

  function automatic logic [31:0] magnitude(logic [31:0] v, output logic neg);
    neg = v[31];
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  function automatic fraction_t compute_fraction(logic [1:0] k, logic [31:0] an,
                                                 logic [31:0] ad, logic [31:0] bn,
                                                 logic [31:0] bd);
    fraction_t r;
    logic nan_s, dan_s, nbn_s, dbn_s, aneg, bneg, s1, s2, neg;
    logic [63:0] anm, adm, bnm, bdm, g, m1, m2, nm, dm;
    r = '0;
    if (ad == 0 || bd == 0) begin
      r.st = rau_pkg::ST_ZDEN;
      return r;
    end
    anm = magnitude(an, nan_s);
    adm = magnitude(ad, dan_s);
    bnm = magnitude(bn, nbn_s);
    bdm = magnitude(bd, dbn_s);
    aneg = nan_s != dan_s;
    bneg = nbn_s != dbn_s;
    if (anm == 0) begin adm = 1; aneg = 0; end
    else begin g = gcd64(anm, adm); anm = anm / g; adm = adm / g; end
    if (bnm == 0) begin bdm = 1; bneg = 0; end
    else begin g = gcd64(bnm, bdm); bnm = bnm / g; bdm = bdm / g; end
    if (k == rau_pkg::KIND_DIV && bnm == 0) begin
      r.st = rau_pkg::ST_DIV0;
      return r;
    end
    case (k)
      rau_pkg::KIND_ADD, rau_pkg::KIND_SUB: begin
        m1 = anm * bdm;
        m2 = bnm * adm;
        s1 = aneg;
        s2 = (k == rau_pkg::KIND_SUB) ? !bneg : bneg;
        if (m2 == 0) s2 = s1;
        if (m1 == 0) s1 = s2;
        if (s1 == s2) begin nm = m1 + m2; neg = s1; end
        else if (m1 >= m2) begin nm = m1 - m2; neg = s1; end
        else begin nm = m2 - m1; neg = s2; end
        dm = adm * bdm;
      end
      rau_pkg::KIND_MUL: begin
        nm = anm * bnm;
        dm = adm * bdm;
        neg = aneg != bneg;
      end
      default: begin
        nm = anm * bdm;
        dm = adm * bnm;
        neg = aneg != bneg;
      end
    endcase
    if (nm == 0) begin
      r.num = 0;
      r.den = 1;
      return r;
    end
    g = gcd64(nm, dm);
    nm = nm / g;
    dm = dm / g;
    if (nm > 64'h7fffffff || dm > 64'h7fffffff) begin
      r.st = rau_pkg::ST_OVF;
      return r;
    end
    r.num = neg ? (32'd0 - nm[31:0]) : nm[31:0];
    r.den = dm[30:0];
    r.st = rau_pkg::ST_OK;
    return r;
  endfunction

  assign pending = expected_fractions.size();

  always @(posedge clk) begin
    fraction_t e;
    if (rst) begin
      errors <= 0;
      results_seen <= 0;
    end else begin
      if (in_valid && in_ready)
        expected_fractions.push_back(compute_fraction(kind, a_num, a_den, b_num, b_den));
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (expected_fractions.size() == 0) begin
          $error("unexpected result transaction %0d/%0d status %0d",
                 $signed(res_num), res_den, status);
          errors <= errors + 1;
        end else begin
          e = expected_fractions.pop_front();
          if (res_num !== e.num || res_den !== e.den || status !== e.st) begin
            if (res_num !== e.num)
              $error("res_num expected %0d got %0d", $signed(e.num), $signed(res_num));
            if (res_den !== e.den)
              $error("res_den expected %0d got %0d", e.den, res_den);
            if (status !== e.st)
              $error("status expected %0d got %0d", e.st, status);
            errors <= errors + 1;
          end
        end
      end
    end
  end

endmodule

// ----- verif/rational_arithmetic_unit_test.sv -----
// testbench top for the rational arithmetic unit: stimulus and verdict
module rational_arithmetic_unit_test;

  localparam int RANDOM_ITEMS = 930;
  localparam int STALL_LIMIT = 200000;

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_ready;
  logic [1:0]  kind = rau_pkg::KIND_ADD;
  logic [31:0] a_num = 0, a_den = 1, b_num = 0, b_den = 1;
  logic        out_valid;
  logic        out_ready = 0;
  logic [31:0] res_num;
  logic [30:0] res_den;
  logic [1:0]  status;
  int          errors, pending, results_seen;
  int          idle_cycles = 0;
  int          sent = 0;
  int          rx_wait = 0;
  bit          sending_done = 0;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  rational_arithmetic_unit dut (
    .clk, .rst, .in_valid, .in_ready, .kind, .a_num, .a_den, .b_num, .b_den,
    .out_valid, .out_ready, .res_num, .res_den, .status
  );

  rational_arithmetic_unit_checker checker_i (
    .clk, .rst, .in_valid, .in_ready, .kind, .a_num, .a_den, .b_num, .b_den,
    .out_valid, .out_ready, .res_num, .res_den, .status,
    .errors, .pending, .results_seen
  );

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'h80000000;
      1: return 32'h7fffffff;
      2: return 32'h80000001;
      3: return 0;
      4, 5: return $urandom_range(0, 40) - 20;
      6: return $urandom_range(0, 2000) * (($urandom_range(0, 1) != 0) ? -1 : 1);
      7: return 32'd1 << $urandom_range(0, 31);
      default: return $urandom();
    endcase
  endfunction

  task automatic send(logic [1:0] k, logic [31:0] an, logic [31:0] ad,
                      logic [31:0] bn, logic [31:0] bd);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
    if (gap != 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    kind <= k;
    a_num <= an;
    a_den <= ad;
    b_num <= bn;
    b_den <= bd;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  // receiver stalls, one wait drawn per result transaction until sending is done
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 0;
      rx_wait <= $urandom_range(0, 11);
    end else if (out_valid && out_ready) begin
      out_ready <= 0;
      rx_wait <= sending_done ? 0 : $urandom_range(0, 11);
    end else if (out_valid && !out_ready) begin
      if (rx_wait == 0)
        out_ready <= 1;
      else
        rx_wait <= rx_wait - 1;
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    logic [31:0] zn;
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // directed corners
    send(rau_pkg::KIND_ADD, 1, 2, 1, 3);
    send(rau_pkg::KIND_SUB, 1, 2, 1, 2);
    send(rau_pkg::KIND_MUL, -6, 4, 10, -15);
    send(rau_pkg::KIND_DIV, 3, 4, -9, 8);
    send(rau_pkg::KIND_ADD, 5, 0, 1, 1);
    send(rau_pkg::KIND_DIV, 1, 1, 2, 0);
    send(rau_pkg::KIND_DIV, 7, 3, 0, 5);
    send(rau_pkg::KIND_DIV, 0, 3, 0, -5);
    send(rau_pkg::KIND_MUL, 32'h7fffffff, 1, 32'h7fffffff, 1);
    send(rau_pkg::KIND_ADD, 32'h80000000, 1, 0, 1);
    send(rau_pkg::KIND_SUB, 32'h80000000, 2, 0, 1);
    send(rau_pkg::KIND_MUL, 32'h80000000, 32'h80000000, 5, -7);
    send(rau_pkg::KIND_ADD, 32'h7fffffff, 1, 1, 1);
    send(rau_pkg::KIND_SUB, -5, 1, 32'h7fffffff, 32'h7ffffffe);
    send(rau_pkg::KIND_DIV, 32'h80000001, 1, 32'h80000001, 1);
    send(rau_pkg::KIND_ADD, 0, -9, 0, 32'h80000000);
    send(rau_pkg::KIND_SUB, 32'hffffffff, 32'hffffffff, 32'hffffffff, 32'hffffffff);
    send(rau_pkg::KIND_MUL, 32'haaaaaaaa, 32'h55555555, 32'h55555555, 32'haaaaaaaa);
    send(rau_pkg::KIND_DIV, 0, 1, 32'h80000000, 32'h7fffffff);
    in_valid <= 0;
    @(posedge clk);
    wait (pending == 0);
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      zn = pick_value();
      send(2'($urandom_range(0, 3)), pick_value(),
           ($urandom_range(0, 30) == 0) ? 32'd0 : ((zn == 0) ? 32'd3 : zn),
           pick_value(), ($urandom_range(0, 30) == 0) ? 32'd0 : pick_value() | 32'd1);
      if (i == RANDOM_ITEMS / 2) begin
        in_valid <= 0;
        @(posedge clk);
        wait (pending == 0);
      end
    end
    in_valid <= 0;
    sending_done = 1;
    @(posedge clk);
    wait (pending == 0);
    repeat (500) @(posedge clk);
    $display("covered %0d transactions across all four operations, %0d results checked",
             sent, results_seen);
    $display("including zero denominators, division by zero and overflow corners");
    if (errors == 0 && pending == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- rational_arithmetic_unit.f -----
src/rau_pkg.sv
src/rau_div.sv
src/rational_arithmetic_unit.sv
verif/rational_arithmetic_unit_checker.sv
verif/rational_arithmetic_unit_test.sv
